[hdl/i2c_pkg.sv]
// ----------------------------------------------------------------------------
// i2c_pkg: shared definitions for the im2col address generator
// Field widths, configuration register indexes, command codes and the
// operand bundle of the shared multiplier.
// ----------------------------------------------------------------------------
package i2c_pkg;

	localparam int MAX_KERNEL    = 7;
	localparam int MAX_IMAGE_DIM = 1024;
	localparam int MAX_CHANNELS  = 1024;

	localparam int DIM_W      = 11;
	localparam int POS_W      = 10;
	localparam int KSZ_W      = 6;
	localparam int NIB_W      = 4;
	localparam int BYTE_W     = 8;
	localparam int KIDX_W     = 3;
	localparam int COORD_W    = 16;
	localparam int SRC_OFF_W  = 30;
	localparam int DST_OFF_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int MUL_A_W    = 30;
	localparam int MUL_B_W    = 21;
	localparam int PROD_W     = 30;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DILATION   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PAD        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = 3'd7;

	localparam logic ACT_COPY = 1'b0;
	localparam logic ACT_FILL = 1'b1;

	typedef struct packed {
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

[hdl/i2c_if.sv]
// ----------------------------------------------------------------------------
// i2c_if: request channels of the im2col address generator
// The position channel carries output positions in, the command channel
// carries one copy or fill command per kernel tap out.
// ----------------------------------------------------------------------------
interface i2c_pos_if;
	import i2c_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  out_row;
	logic [POS_W-1:0]  out_col;

	modport source (output valid, output out_row, output out_col, input ready);
	modport sink   (input valid, input out_row, input out_col, output ready);
endinterface

interface i2c_cmd_if;
	import i2c_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [SRC_OFF_W-1:0] src_offset;
	logic [DST_OFF_W-1:0] dst_offset;
	logic [BYTE_W-1:0]    fill_byte;
	logic                 last_tap;

	modport source (output valid, output action, output src_offset, output dst_offset,
		output fill_byte, output last_tap, input ready);
	modport sink   (input valid, input action, input src_offset, input dst_offset,
		input fill_byte, input last_tap, output ready);
endinterface

[hdl/i2c_mul.sv]
// ----------------------------------------------------------------------------
// i2c_mul: shared multiplier
// Multiplies a 30-bit operand by a 21-bit operand and registers the low
// 30 bits of the product; the result is registered and ready in the cycle after the operands.
// ----------------------------------------------------------------------------
module i2c_mul (
	input  logic                          clk,
	input  i2c_pkg::mul_req_t             req,
	output logic [i2c_pkg::PROD_W-1:0]    prod
);
	import i2c_pkg::*;

	logic [MUL_A_W+MUL_B_W-1:0] full;
	logic [PROD_W-1:0]          prod_q;

	// Only the low bits are kept, so signed operands given in two's
	// complement still give the right product modulo the offset range.
	assign full = req.a * req.b;

	always_ff @(posedge clk) begin
		prod_q <= full[PROD_W-1:0];
	end

	assign prod = prod_q;

endmodule

[hdl/im2col_address_generator.sv]
// Throughput: one command per cycle while the command sink is ready, and
// kernel_h * kernel_w commands per position. A position runs through the
// eight-step setup on the one shared multiplier and then its taps; the next
// position is accepted only once the last tap of the current one is issued.
// Reset: the configuration registers return to their reset values and the
// sequencer goes idle; no memory is present and no clearing pass is run.
// ----------------------------------------------------------------------------
// im2col_address_generator: NHWC im2col copy/fill command generator
// Expands one output position of a convolution into one command per kernel
// tap, either copying a source channel vector or filling with the zero point.
// ----------------------------------------------------------------------------
module im2col_address_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [i2c_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [i2c_pkg::CFG_DATA_W-1:0]   cfg_data,
	i2c_pos_if.sink                          pos,
	i2c_cmd_if.source                        cmd
);
	import i2c_pkg::*;

	// Sequencer codes. The eight setup steps share one multiplier: M0 to M6
	// each issue a product, and M1 to M7 each pick up the one from the step before.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_M0   = 4'd1;
	localparam logic [3:0] ST_M1   = 4'd2;
	localparam logic [3:0] ST_M2   = 4'd3;
	localparam logic [3:0] ST_M3   = 4'd4;
	localparam logic [3:0] ST_M4   = 4'd5;
	localparam logic [3:0] ST_M5   = 4'd6;
	localparam logic [3:0] ST_M6   = 4'd7;
	localparam logic [3:0] ST_M7   = 4'd8;
	localparam logic [3:0] ST_TAP  = 4'd9;

	// Configuration registers.
	logic [DIM_W-1:0]  src_height_q;
	logic [DIM_W-1:0]  src_width_q;
	logic [DIM_W-1:0]  channels_q;
	logic [KSZ_W-1:0]  kernel_q;
	logic [BYTE_W-1:0] stride_q;
	logic [BYTE_W-1:0] dilation_q;
	logic [BYTE_W-1:0] pad_q;
	logic [BYTE_W-1:0] zero_point_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_height_q <= DIM_W'(1);
			src_width_q  <= DIM_W'(1);
			channels_q   <= DIM_W'(1);
			kernel_q     <= KSZ_W'(9);
			stride_q     <= BYTE_W'(17);
			dilation_q   <= BYTE_W'(17);
			pad_q        <= '0;
			zero_point_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_CHANNELS:   channels_q   <= cfg_data;
				REG_KERNEL:     kernel_q     <= cfg_data[KSZ_W-1:0];
				REG_STRIDE:     stride_q     <= cfg_data[BYTE_W-1:0];
				REG_DILATION:   dilation_q   <= cfg_data[BYTE_W-1:0];
				REG_PAD:        pad_q        <= cfg_data[BYTE_W-1:0];
				REG_ZERO_POINT: zero_point_q <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective geometry. A kernel dimension of zero counts as one, and the
	// image and channel counts saturate at their maxima.
	logic [KIDX_W-1:0] kh_raw, kw_raw, kh, kw;
	logic [DIM_W-1:0]  h, w, c;
	logic [NIB_W-1:0]  str_y, str_x, dil_y, dil_x, pad_y, pad_x;

	assign kh_raw = kernel_q[KSZ_W-1:KIDX_W];
	assign kw_raw = kernel_q[KIDX_W-1:0];
	assign kh = (kh_raw == '0) ? KIDX_W'(1) :
		((int'(kh_raw) > MAX_KERNEL) ? KIDX_W'(MAX_KERNEL) : kh_raw);
	assign kw = (kw_raw == '0) ? KIDX_W'(1) :
		((int'(kw_raw) > MAX_KERNEL) ? KIDX_W'(MAX_KERNEL) : kw_raw);
	assign h = (int'(src_height_q) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : src_height_q;
	assign w = (int'(src_width_q) > MAX_IMAGE_DIM) ? DIM_W'(MAX_IMAGE_DIM) : src_width_q;
	assign c = (int'(channels_q) > MAX_CHANNELS) ? DIM_W'(MAX_CHANNELS) : channels_q;

	assign str_y = stride_q[BYTE_W-1:NIB_W];
	assign str_x = stride_q[NIB_W-1:0];
	assign dil_y = dilation_q[BYTE_W-1:NIB_W];
	assign dil_x = dilation_q[NIB_W-1:0];
	assign pad_y = pad_q[BYTE_W-1:NIB_W];
	assign pad_x = pad_q[NIB_W-1:0];

	// Sequencer and working registers. Coordinates are kept in two's
	// complement so that taps above or left of the image come out negative.
	logic [3:0]           state_q;
	logic [POS_W-1:0]     row_q, col_q;
	logic [COORD_W-1:0]   sy0_q, sx0_q, sy_q, sx_q;
	logic [MUL_B_W-1:0]   wc_q;
	logic [SRC_OFF_W-1:0] dxc_q, dyc_q, acc_q;
	logic [SRC_OFF_W-1:0] off_row_q, off_q;
	logic [DST_OFF_W-1:0] dst_q;
	logic [KIDX_W-1:0]    ky_q, kx_q;

	// Output register.
	logic                 cmd_valid_q;
	logic                 action_q;
	logic [SRC_OFF_W-1:0] src_offset_q;
	logic [DST_OFF_W-1:0] dst_offset_q;
	logic [BYTE_W-1:0]    fill_byte_q;
	logic                 last_tap_q;

	mul_req_t          mul_req;
	logic [PROD_W-1:0] prod;

	i2c_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (prod)
	);

	// Operands for setup steps M0 to M6: the start coordinates, the row pitch
	// w*c, the column and row steps of the source offset, and the two terms
	// of the offset of the first tap.
	always_comb begin
		mul_req = '0;
		unique case (state_q)
			ST_M0: begin
				mul_req.a = MUL_A_W'(row_q);
				mul_req.b = MUL_B_W'(str_y);
			end
			ST_M1: begin
				mul_req.a = MUL_A_W'(col_q);
				mul_req.b = MUL_B_W'(str_x);
			end
			ST_M2: begin
				mul_req.a = MUL_A_W'(w);
				mul_req.b = MUL_B_W'(c);
			end
			ST_M3: begin
				mul_req.a = MUL_A_W'(dil_x);
				mul_req.b = MUL_B_W'(c);
			end
			ST_M4: begin
				mul_req.a = MUL_A_W'(dil_y);
				mul_req.b = wc_q;
			end
			ST_M5: begin
				mul_req.a = {{(MUL_A_W-COORD_W){sy0_q[COORD_W-1]}}, sy0_q};
				mul_req.b = wc_q;
			end
			ST_M6: begin
				mul_req.a = {{(MUL_A_W-COORD_W){sx0_q[COORD_W-1]}}, sx0_q};
				mul_req.b = MUL_B_W'(c);
			end
			default: mul_req = '0;
		endcase
	end

	// In the tap state, a tap is issued whenever the output register is free or being emptied.
	logic tap_fire, row_end, last_now, in_image;

	assign tap_fire = (state_q == ST_TAP) && (!cmd_valid_q || cmd.ready);
	assign row_end  = (kx_q == kw - KIDX_W'(1));
	assign last_now = row_end && (ky_q == kh - KIDX_W'(1));
	// Both coordinates are non-negative when their sign bits are clear, and
	// then an unsigned compare against the image size finishes the test.
	assign in_image = !sy_q[COORD_W-1] && !sx_q[COORD_W-1] &&
		(sy_q < COORD_W'(h)) && (sx_q < COORD_W'(w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ky_q    <= '0;
			kx_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (pos.valid) state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6:   state_q <= ST_M7;
				ST_M7: begin
					state_q <= ST_TAP;
					ky_q    <= '0;
					kx_q    <= '0;
				end
				ST_TAP: if (tap_fire) begin
					if (row_end) begin
						kx_q <= '0;
						ky_q <= ky_q + KIDX_W'(1);
						if (last_now) state_q <= ST_IDLE;
					end else begin
						kx_q <= kx_q + KIDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer; they carry no reset.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q <= pos.out_row;
				col_q <= pos.out_col;
			end
			ST_M1: sy0_q <= prod[COORD_W-1:0] - COORD_W'(pad_y);
			ST_M2: sx0_q <= prod[COORD_W-1:0] - COORD_W'(pad_x);
			ST_M3: wc_q  <= prod[MUL_B_W-1:0];
			ST_M4: dxc_q <= prod;
			ST_M5: dyc_q <= prod;
			ST_M6: acc_q <= prod;
			ST_M7: begin
				off_row_q <= acc_q + prod;
				off_q     <= acc_q + prod;
				sy_q      <= sy0_q;
				sx_q      <= sx0_q;
				dst_q     <= '0;
			end
			ST_TAP: if (tap_fire) begin
				dst_q <= dst_q + DST_OFF_W'(c);
				if (row_end) begin
					sy_q      <= sy_q + COORD_W'(dil_y);
					sx_q      <= sx0_q;
					off_row_q <= off_row_q + dyc_q;
					off_q     <= off_row_q + dyc_q;
				end else begin
					sx_q  <= sx_q + COORD_W'(dil_x);
					off_q <= off_q + dxc_q;
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a command until the sink takes it, while the
	// next tap is already worked out behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (tap_fire) begin
			cmd_valid_q <= 1'b1;
		end else if (cmd.ready) begin
			cmd_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tap_fire) begin
			action_q     <= in_image ? ACT_COPY : ACT_FILL;
			src_offset_q <= in_image ? off_q : '0;
			fill_byte_q  <= in_image ? '0 : zero_point_q;
			dst_offset_q <= dst_q;
			last_tap_q   <= last_now;
		end
	end

	assign pos.ready      = (state_q == ST_IDLE);
	assign cmd.valid      = cmd_valid_q;
	assign cmd.action     = action_q;
	assign cmd.src_offset = src_offset_q;
	assign cmd.dst_offset = dst_offset_q;
	assign cmd.fill_byte  = fill_byte_q;
	assign cmd.last_tap   = last_tap_q;

`ifndef SYNTHESIS
	// A fill command never carries a source offset.
	a_fill_no_src: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.action == ACT_FILL) |-> (cmd.src_offset == '0))
		else $error("fill command with a non-zero source offset");

	// An accepted position moves the block into the first setup step and drops the position ready.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pos.valid && pos.ready) |=> (!pos.ready && state_q == ST_M0))
		else $error("position channel ready during setup");

	// The tap counters stay inside the kernel while taps are issued.
	a_tap_in_kernel: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP) |-> (kx_q < kw && ky_q < kh))
		else $error("tap counter outside the kernel");

	// The final tap of a position sends the sequencer back to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_fire && last_now) |=> (state_q == ST_IDLE && cmd.valid && cmd.last_tap))
		else $error("final tap did not close the position");
`endif

endmodule
